FILE: hw/rtl/security_access_unlock_sequencer_macros.svh
// ----------------------------------------------------------------------------
// security access unlock sequencer assertion macros
// concurrent assertion forms used by the sequencer controller module
// ----------------------------------------------------------------------------
`ifndef SECURITY_ACCESS_UNLOCK_SEQUENCER_MACROS_SVH
`define SECURITY_ACCESS_UNLOCK_SEQUENCER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SAU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/sau_pkg.sv
// ----------------------------------------------------------------------------
// sau_pkg
// request, response, command and status types plus protocol and key constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sau_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNLOCK_KEY     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNLOCK_SERVICE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIAG_SESSION   = 2'd2;

   // diagnostic service ids and frame bytes
   localparam logic [7:0] SID_SESSION_REQ    = 8'h10;
   localparam logic [7:0] SID_SESSION_RSP    = 8'h50;
   localparam logic [7:0] SID_SECURITY_REQ   = 8'h27;
   localparam logic [7:0] SID_SECURITY_RSP   = 8'h67;
   localparam logic [7:0] KA_OFF_BYTE0       = 8'h01;
   localparam logic [7:0] SID_TESTER_PRESENT = 8'h3E;
   localparam logic [7:0] SESSION_KWP        = 8'hC0;

   localparam logic [3:0] RX_LEN_SHORT = 4'd2;
   localparam logic [3:0] RX_LEN_SEED  = 4'd6;
   localparam logic [2:0] TX_LEN_NONE  = 3'd0;
   localparam logic [2:0] TX_LEN_SHORT = 3'd2;
   localparam logic [2:0] TX_LEN_KEY   = 3'd6;

   // key transform constants: divisor p, quotient weight q, remainder weight r
   localparam logic [7:0] MIX_A_P = 8'hB2;
   localparam logic [7:0] MIX_A_Q = 8'h3F;
   localparam logic [7:0] MIX_A_R = 8'hAA;
   localparam logic [7:0] MIX_B_P = 8'hB1;
   localparam logic [7:0] MIX_B_Q = 8'h02;
   localparam logic [7:0] MIX_B_R = 8'hAB;

   // ceil(2^23 / p), exact quotient for magnitudes up to 2^15
   localparam int         MIX_RECIP_SHIFT = 23;
   localparam logic [15:0] MIX_A_RECIP = 16'd47128;
   localparam logic [15:0] MIX_B_RECIP = 16'd47394;

   // p*r + q, added once to a negative transform value
   localparam logic [15:0] MIX_A_WRAP = 16'd30323;
   localparam logic [15:0] MIX_B_WRAP = 16'd30269;

   typedef struct packed {
      logic       mode;
      logic [3:0] rx_len;
      logic [7:0] rx_byte0;
      logic [7:0] rx_byte1;
      logic [7:0] rx_byte2;
      logic [7:0] rx_byte3;
      logic [7:0] rx_byte4;
      logic [7:0] rx_byte5;
   } sau_req_type;

   typedef struct packed {
      logic [2:0] tx_len;
      logic [7:0] tx_byte0;
      logic [7:0] tx_byte1;
      logic [7:0] tx_byte2;
      logic [7:0] tx_byte3;
      logic [7:0] tx_byte4;
      logic [7:0] tx_byte5;
      logic       keepalive_on;
      logic       keepalive_kwp;
      logic       awaiting_key;
   } sau_rsp_type;

   typedef enum logic [1:0] {
      RSP_NONE     = 2'd0,
      RSP_SESSION  = 2'd1,
      RSP_SEED_REQ = 2'd2,
      RSP_KEY      = 2'd3
   } sau_rsp_kind_type;

   typedef enum logic [1:0] {
      OP_PIN      = 2'd0,
      OP_SEED_HI  = 2'd1,
      OP_SEED_MID = 2'd2,
      OP_MIX_HI   = 2'd3
   } sau_op_sel_type;

   typedef struct packed {
      logic             load_req;
      sau_op_sel_type   op_sel;
      logic             set_b;
      logic             cap_hi;
      logic             merge_hi;
      logic             cap_lo;
      logic             load_rsp;
      sau_rsp_kind_type rsp_kind;
      logic             ka_on;
      logic             kwp;
      logic             awaiting;
   } sau_cmd_type;

   typedef struct packed {
      logic mode;
      logic ka_off;
      logic seed_req;
      logic seed_reply;
      logic session_kwp;
   } sau_status_type;

endpackage

FILE: hw/rtl/sau_datapath.sv
// ----------------------------------------------------------------------------
// sau_datapath
// config registers, frame decode, three stage key transform pipeline and
// response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sau_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sau_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sau_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  sau_pkg::sau_req_type              req_data,
   output sau_pkg::sau_rsp_type              rsp_data,
   input  sau_pkg::sau_cmd_type              cmd,
   output sau_pkg::sau_status_type           status
);
   import sau_pkg::*;

   logic [15:0] key_ff;
   logic [7:0]  service_ff;
   logic [7:0]  session_ff;

   sau_req_type req_ff;
   sau_rsp_type rsp_ff, rsp_in;

   logic [15:0] hi_ff, lo_ff;
   logic [15:0] mix_hi;
   logic [15:0] mix_lo;

   // transform pipeline
   logic [15:0] operand;
   logic        s0_neg;
   logic [15:0] s0_mag;
   logic [15:0] s0_recip;
   logic [31:0] s0_prod;

   logic [15:0] s1_mag_ff;
   logic [7:0]  s1_quo_ff;
   logic        s1_neg_ff;
   logic        s1_setb_ff;

   logic [7:0]  s1_p;
   logic [15:0] s1_qp;
   logic [15:0] s1_rem;

   logic [7:0]  s2_rem_ff;
   logic [7:0]  s2_quo_ff;
   logic        s2_neg_ff;
   logic        s2_setb_ff;

   logic [7:0]         s2_r, s2_q;
   logic [15:0]        s2_wrap;
   logic [15:0]        s2_pr, s2_pq;
   logic signed [17:0] s2_t, s2_v;

   logic [15:0] mix_res_ff;

   logic [15:0] key_top;
   logic [7:0]  service_inc;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         service_ff <= '0;
         session_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UNLOCK_KEY:     key_ff     <= csr_wdata;
            CSR_UNLOCK_SERVICE: service_ff <= csr_wdata[7:0];
            CSR_DIAG_SESSION:   session_ff <= csr_wdata[7:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // frame decode
   always_comb begin
      status.mode        = req_ff.mode;
      status.ka_off      = (req_ff.rx_len == RX_LEN_SHORT) && (req_ff.rx_byte0 == KA_OFF_BYTE0)
                           && (req_ff.rx_byte1 == SID_TESTER_PRESENT);
      status.seed_req    = (req_ff.rx_len == RX_LEN_SHORT)
                           && (req_ff.rx_byte0 == SID_SESSION_RSP)
                           && (req_ff.rx_byte1 == service_ff);
      status.seed_reply  = (req_ff.rx_len == RX_LEN_SEED)
                           && (req_ff.rx_byte0 == SID_SECURITY_RSP)
                           && (req_ff.rx_byte1 == service_ff);
      status.session_kwp = (session_ff == SESSION_KWP);
   end

   assign mix_hi = hi_ff | mix_res_ff;
   assign mix_lo = lo_ff | mix_res_ff;

   // stage 0: operand, magnitude, quotient by reciprocal
   always_comb begin
      case (cmd.op_sel)
         OP_PIN:      operand = key_ff;
         OP_SEED_HI:  operand = {req_ff.rx_byte5, req_ff.rx_byte2};
         OP_SEED_MID: operand = {req_ff.rx_byte4, req_ff.rx_byte3};
         OP_MIX_HI:   operand = mix_hi;
         default:     operand = key_ff;
      endcase
      s0_neg   = operand[15];
      s0_mag   = s0_neg ? (~operand + 16'd1) : operand;
      s0_recip = cmd.set_b ? MIX_B_RECIP : MIX_A_RECIP;
      s0_prod  = {16'd0, s0_mag} * {16'd0, s0_recip};
   end

   always_ff @(posedge clock) begin
      s1_mag_ff  <= s0_mag;
      s1_quo_ff  <= s0_prod[MIX_RECIP_SHIFT+7:MIX_RECIP_SHIFT];
      s1_neg_ff  <= s0_neg;
      s1_setb_ff <= cmd.set_b;
   end

   // stage 1: remainder
   always_comb begin
      s1_p   = s1_setb_ff ? MIX_B_P : MIX_A_P;
      s1_qp  = {8'd0, s1_quo_ff} * {8'd0, s1_p};
      s1_rem = s1_mag_ff - s1_qp;
   end

   always_ff @(posedge clock) begin
      s2_rem_ff  <= s1_rem[7:0];
      s2_quo_ff  <= s1_quo_ff;
      s2_neg_ff  <= s1_neg_ff;
      s2_setb_ff <= s1_setb_ff;
   end

   // stage 2: weighted difference, sign restore, wrap of negatives
   always_comb begin
      s2_r    = s2_setb_ff ? MIX_B_R : MIX_A_R;
      s2_q    = s2_setb_ff ? MIX_B_Q : MIX_A_Q;
      s2_wrap = s2_setb_ff ? MIX_B_WRAP : MIX_A_WRAP;
      s2_pr   = {8'd0, s2_rem_ff} * {8'd0, s2_r};
      s2_pq   = {8'd0, s2_quo_ff} * {8'd0, s2_q};
      s2_t    = $signed({2'b00, s2_pr}) - $signed({2'b00, s2_pq});
      s2_v    = s2_neg_ff ? -s2_t : s2_t;
      if (s2_v[17]) begin
         s2_v = s2_v + $signed({2'b00, s2_wrap});
      end
   end

   always_ff @(posedge clock) begin
      mix_res_ff <= s2_v[15:0];
   end

   // key halves
   always_ff @(posedge clock) begin
      if (cmd.cap_hi) begin
         hi_ff <= mix_res_ff;
      end else if (cmd.merge_hi) begin
         hi_ff <= mix_hi;
      end
      if (cmd.cap_lo) begin
         lo_ff <= mix_res_ff;
      end
   end

   // response assembly
   always_comb begin
      key_top     = mix_lo[15] ? 16'hFFFF : hi_ff;
      service_inc = service_ff + 8'd1;
      rsp_in      = '0;
      case (cmd.rsp_kind)
         RSP_NONE: begin
            rsp_in.tx_len = TX_LEN_NONE;
         end
         RSP_SESSION: begin
            rsp_in.tx_len   = TX_LEN_SHORT;
            rsp_in.tx_byte0 = SID_SESSION_REQ;
            rsp_in.tx_byte1 = session_ff;
         end
         RSP_SEED_REQ: begin
            rsp_in.tx_len   = TX_LEN_SHORT;
            rsp_in.tx_byte0 = SID_SECURITY_REQ;
            rsp_in.tx_byte1 = service_ff;
         end
         RSP_KEY: begin
            rsp_in.tx_len   = TX_LEN_KEY;
            rsp_in.tx_byte0 = SID_SECURITY_REQ;
            rsp_in.tx_byte1 = service_inc;
            rsp_in.tx_byte2 = mix_lo[7:0];
            rsp_in.tx_byte3 = mix_lo[15:8];
            rsp_in.tx_byte4 = key_top[7:0];
            rsp_in.tx_byte5 = key_top[15:8];
         end
         default: begin
            rsp_in.tx_len = TX_LEN_NONE;
         end
      endcase
      rsp_in.keepalive_on  = cmd.ka_on;
      rsp_in.keepalive_kwp = cmd.kwp;
      rsp_in.awaiting_key  = cmd.awaiting;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/sau_ctrl.sv
// ----------------------------------------------------------------------------
// sau_ctrl
// handshake state machine, session flags and key transform sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "security_access_unlock_sequencer_macros.svh"

module sau_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  sau_pkg::sau_status_type  status,
   output sau_pkg::sau_cmd_type     cmd
);
   import sau_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECODE = 3'b010,
      ST_KEY    = 3'b100
   } sau_state_type;

   localparam logic [2:0] STEP_PIN     = 3'd0;
   localparam logic [2:0] STEP_SEED_HI = 3'd1;
   localparam logic [2:0] STEP_SEED_MD = 3'd2;
   localparam logic [2:0] STEP_CAP_HI  = 3'd3;
   localparam logic [2:0] STEP_MERGE   = 3'd4;
   localparam logic [2:0] STEP_CAP_LO  = 3'd5;
   localparam logic [2:0] STEP_DRAIN   = 3'd6;
   localparam logic [2:0] STEP_LAST    = 3'd7;

   sau_state_type st_ff, st_in;
   logic [2:0]    step_ff, step_in;
   logic          wait_ff, wait_in;
   logic          ka_ff, ka_in;
   logic          kwp_ff, kwp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   always_comb begin
      st_in     = st_ff;
      step_in   = step_ff;
      wait_in   = wait_ff;
      ka_in     = ka_ff;
      kwp_in    = kwp_ff;
      req_ready = 1'b0;
      slot_free = !rsp_valid_ff || rsp_ready;
      cmd       = '0;
      cmd.op_sel   = OP_PIN;
      cmd.rsp_kind = RSP_NONE;

      case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               st_in        = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (slot_free) begin
               if (!status.mode) begin
                  kwp_in       = status.session_kwp;
                  ka_in        = 1'b1;
                  wait_in      = 1'b1;
                  cmd.load_rsp = 1'b1;
                  cmd.rsp_kind = RSP_SESSION;
                  st_in        = ST_IDLE;
               end else begin
                  if (status.ka_off) begin
                     ka_in = 1'b0;
                  end
                  if (wait_ff && status.seed_req) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_kind = RSP_SEED_REQ;
                     st_in        = ST_IDLE;
                  end else if (wait_ff && status.seed_reply) begin
                     wait_in = 1'b0;
                     step_in = STEP_PIN;
                     st_in   = ST_KEY;
                  end else begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_kind = RSP_NONE;
                     st_in        = ST_IDLE;
                  end
               end
            end
         end
         ST_KEY: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               STEP_PIN: begin
                  cmd.op_sel = OP_PIN;
                  cmd.set_b  = 1'b0;
               end
               STEP_SEED_HI: begin
                  cmd.op_sel = OP_SEED_HI;
                  cmd.set_b  = 1'b1;
               end
               STEP_SEED_MD: begin
                  cmd.op_sel = OP_SEED_MID;
                  cmd.set_b  = 1'b0;
               end
               STEP_CAP_HI: begin
                  cmd.cap_hi = 1'b1;
               end
               STEP_MERGE: begin
                  cmd.merge_hi = 1'b1;
                  cmd.op_sel   = OP_MIX_HI;
                  cmd.set_b    = 1'b1;
               end
               STEP_CAP_LO: begin
                  cmd.cap_lo = 1'b1;
               end
               STEP_DRAIN: begin
               end
               STEP_LAST: begin
                  cmd.load_rsp = 1'b1;
                  cmd.rsp_kind = RSP_KEY;
                  st_in        = ST_IDLE;
               end
               default: begin
                  st_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      cmd.ka_on    = ka_in;
      cmd.kwp      = kwp_in;
      cmd.awaiting = wait_in;

      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         step_ff      <= STEP_PIN;
         wait_ff      <= 1'b0;
         ka_ff        <= 1'b0;
         kwp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         step_ff      <= step_in;
         wait_ff      <= wait_in;
         ka_ff        <= ka_in;
         kwp_ff       <= kwp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SAU_ASSERT_NEXT(a_key_done, clock, reset, (st_ff == ST_KEY) && (step_ff == STEP_LAST), rsp_valid_ff && (st_ff == ST_IDLE), "key sequence did not deliver a response")
   `SAU_ASSERT_SAME(a_key_slot, clock, reset, st_ff == ST_KEY, !rsp_valid_ff, "response slot busy during key computation")
   `SAU_ASSERT_SAME(a_key_wait, clock, reset, st_ff == ST_KEY, !wait_ff, "seed wait still set during key computation")

endmodule

FILE: hw/rtl/security_access_unlock_sequencer.sv
// ----------------------------------------------------------------------------
// security_access_unlock_sequencer
// a new request is taken only in idle, once the previous one has been decoded
// or, for a seed reply, once its key sequence has loaded the response
// the key path runs through the shared three stage transform pipeline and
// waits for the upper key half before the final transform can issue
// synchronous reset clears config registers, session flags and handshake state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module security_access_unlock_sequencer (
   input  logic                              clock,
   input  logic                              reset,

   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sau_pkg::sau_req_type              req_data,

   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sau_pkg::sau_rsp_type              rsp_data,

   // configuration write port
   input  logic                              csr_we,
   input  logic [sau_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sau_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sau_pkg::*;

   // controller to datapath commands and decode status back
   sau_cmd_type    cmd;
   sau_status_type status;

   // controller: accepts a request, decodes it in the following cycle and
   // either loads the response register at once or runs the eight step key
   // sequence; a new request may be taken while the previous response waits,
   // decode then holds until the response register drains
   sau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config registers, request register, frame matching, the
   // modular transform pipeline (reciprocal quotient, remainder, weighted
   // difference) shared by all four transforms, and the response register
   sau_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
